FILE: design/lsf_pkg.sv
// Shared types and constants for the line substring filter.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package lsf_pkg;

   localparam int PATTERN_W    = 64;
   localparam int LENGTH_W     = 4;
   localparam int LINE_INDEX_W = 32;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 64;

   localparam logic [7:0] NEWLINE_BYTE = 8'd10;

   typedef logic [7:0] byte_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_SEARCH_PATTERN  = 3'd0,
      REG_SEARCH_LENGTH   = 3'd1,
      REG_EXCLUDE_PATTERN = 3'd2,
      REG_EXCLUDE_LENGTH  = 3'd3,
      REG_EXCLUDE_ENABLE  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [PATTERN_W-1:0] search_pattern;
      logic [LENGTH_W-1:0]  search_length;
      logic [PATTERN_W-1:0] exclude_pattern;
      logic [LENGTH_W-1:0]  exclude_length;
      logic                 exclude_enable;
   } cfg_type;

endpackage

`default_nettype wire

FILE: design/line_substring_filter_top.sv
// A text byte is captured in the input register and processed from there; a newline's
// verdict is registered onto the rsp_ ports.
// Throughput: one byte per cycle, but a newline waits there while a verdict is stalled.
// Reset (synchronous, active high) clears the configuration registers, the line
// state, the line counter and both valid flags.
// Depends on lsf_pkg, lsf_csr and lsf_match.
`default_nettype none

module line_substring_filter_top
   import lsf_pkg::*;
#(
   parameter int MAX_PATTERN = 8
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic [7:0]              req_text_byte,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic                         rsp_keep_line,
   output logic                         rsp_has_search,
   output logic                         rsp_has_exclude,
   output logic [LINE_INDEX_W-1:0]      rsp_line_index,
   input  wire logic                    csr_write,
   input  wire logic [CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0]   csr_wdata
);

   localparam int COUNT_W = $clog2(MAX_PATTERN + 1);
   localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_PATTERN);

   cfg_type cfg;

   logic                            in_valid_ff, in_valid_in;
   byte_type                        in_byte_ff, in_byte_in;
   logic [MAX_PATTERN-1:0][7:0]     win_ff, win_in;
   logic [COUNT_W-1:0]              count_ff, count_in;
   logic                            search_seen_ff, search_seen_in;
   logic                            exclude_seen_ff, exclude_seen_in;
   logic [LINE_INDEX_W-1:0]         lines_ff, lines_in;
   logic                            out_valid_ff, out_valid_in;
   logic                            out_search_ff, out_search_in;
   logic                            out_exclude_ff, out_exclude_in;
   logic [LINE_INDEX_W-1:0]         out_index_ff, out_index_in;

   logic                            out_free;
   logic                            is_newline;
   logic                            proc_go;
   logic [MAX_PATTERN-1:0][7:0]     window;
   logic [COUNT_W-1:0]              avail;
   logic                            search_match;
   logic                            exclude_match;
   logic                            line_search;
   logic                            line_exclude;

   lsf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign out_free   = !out_valid_ff || !rsp_stall;
   assign is_newline = (in_byte_ff == NEWLINE_BYTE);
   assign proc_go    = in_valid_ff && (!is_newline || out_free);
   assign req_stall  = in_valid_ff && !proc_go;

   always_comb begin
      window[0] = in_byte_ff;
      for (int k = 1; k < MAX_PATTERN; k++) begin
         window[k] = win_ff[k-1];
      end
      avail = (count_ff == COUNT_MAX) ? COUNT_MAX : count_ff + COUNT_W'(1);
   end

   lsf_match #(
      .MAX_PATTERN (MAX_PATTERN),
      .COUNT_W     (COUNT_W)
   ) u_search (
      .window  (window),
      .avail   (avail),
      .pattern (cfg.search_pattern),
      .length  (cfg.search_length),
      .match   (search_match)
   );

   lsf_match #(
      .MAX_PATTERN (MAX_PATTERN),
      .COUNT_W     (COUNT_W)
   ) u_exclude (
      .window  (window),
      .avail   (avail),
      .pattern (cfg.exclude_pattern),
      .length  (cfg.exclude_length),
      .match   (exclude_match)
   );

   assign line_search  = search_seen_ff || (cfg.search_length == '0);
   assign line_exclude = cfg.exclude_enable &&
                         (exclude_seen_ff || (cfg.exclude_length == '0));

   always_comb begin
      in_valid_in     = in_valid_ff;
      in_byte_in      = in_byte_ff;
      win_in          = win_ff;
      count_in        = count_ff;
      search_seen_in  = search_seen_ff;
      exclude_seen_in = exclude_seen_ff;
      lines_in        = lines_ff;
      out_valid_in    = out_valid_ff && rsp_stall;
      out_search_in   = out_search_ff;
      out_exclude_in  = out_exclude_ff;
      out_index_in    = out_index_ff;

      if (proc_go) begin
         in_valid_in = 1'b0;
         if (is_newline) begin
            out_valid_in    = 1'b1;
            out_search_in   = line_search;
            out_exclude_in  = line_exclude;
            out_index_in    = lines_ff;
            lines_in        = lines_ff + LINE_INDEX_W'(1);
            count_in        = '0;
            search_seen_in  = 1'b0;
            exclude_seen_in = 1'b0;
         end else begin
            win_in          = window;
            count_in        = avail;
            search_seen_in  = search_seen_ff || search_match;
            exclude_seen_in = exclude_seen_ff || exclude_match;
         end
      end

      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_text_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         count_ff        <= '0;
         search_seen_ff  <= 1'b0;
         exclude_seen_ff <= 1'b0;
         lines_ff        <= '0;
         out_valid_ff    <= 1'b0;
      end else begin
         in_valid_ff     <= in_valid_in;
         count_ff        <= count_in;
         search_seen_ff  <= search_seen_in;
         exclude_seen_ff <= exclude_seen_in;
         lines_ff        <= lines_in;
         out_valid_ff    <= out_valid_in;
      end
      in_byte_ff     <= in_byte_in;
      win_ff         <= win_in;
      out_search_ff  <= out_search_in;
      out_exclude_ff <= out_exclude_in;
      out_index_ff   <= out_index_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_keep_line   = out_search_ff && !out_exclude_ff;
   assign rsp_has_search  = out_search_ff;
   assign rsp_has_exclude = out_exclude_ff;
   assign rsp_line_index  = out_index_ff;

   // A newline never overwrites a verdict that is still waiting to be taken.
   assert property (@(posedge clock) disable iff (reset)
      (proc_go && is_newline) |-> (!out_valid_ff || !rsp_stall))
      else $error("Line verdict overwritten while stalled.");

   // Each processed newline advances the line counter by one and clears the line.
   assert property (@(posedge clock) disable iff (reset)
      (proc_go && is_newline) |=>
         (lines_ff == $past(lines_ff) + LINE_INDEX_W'(1)) && (count_ff == '0))
      else $error("Line state not advanced after newline.");

   // The byte count of the current line saturates at the window depth.
   assert property (@(posedge clock) disable iff (reset)
      int'(count_ff) <= MAX_PATTERN)
      else $error("Line byte count beyond window depth.");

   // An exclude verdict is only ever given when exclusion is enabled.
   assert property (@(posedge clock) disable iff (reset)
      (proc_go && is_newline) |=> (!rsp_has_exclude || $past(cfg.exclude_enable)))
      else $error("Exclude verdict without exclusion enabled.");

endmodule

`default_nettype wire

FILE: design/lsf_csr.sv
// Configuration register file of the line substring filter.
// Depends on lsf_pkg for the register indexes and the configuration struct.
`default_nettype none

module lsf_csr
   import lsf_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_write,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            REG_SEARCH_PATTERN:  cfg_in.search_pattern  = csr_wdata[PATTERN_W-1:0];
            REG_SEARCH_LENGTH:   cfg_in.search_length   = csr_wdata[LENGTH_W-1:0];
            REG_EXCLUDE_PATTERN: cfg_in.exclude_pattern = csr_wdata[PATTERN_W-1:0];
            REG_EXCLUDE_LENGTH:  cfg_in.exclude_length  = csr_wdata[LENGTH_W-1:0];
            REG_EXCLUDE_ENABLE:  cfg_in.exclude_enable  = csr_wdata[0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: design/lsf_match.sv
// Parallel compare of one pattern against the byte history window.
// Depends on lsf_pkg for the pattern and length widths.
`default_nettype none

module lsf_match
   import lsf_pkg::*;
#(
   parameter int MAX_PATTERN = 8,
   parameter int COUNT_W     = 4
) (
   input  wire logic [MAX_PATTERN-1:0][7:0] window,
   input  wire logic [COUNT_W-1:0]          avail,
   input  wire logic [PATTERN_W-1:0]        pattern,
   input  wire logic [LENGTH_W-1:0]         length,
   output logic                             match
);

   logic [MAX_PATTERN:1] hit;
   logic [MAX_PATTERN:1] sel;

   // A pattern of length L ends at the newest byte when its byte i equals
   // window byte L-1-i; lengths above the maximum act as the maximum.
   always_comb begin
      for (int l = 1; l <= MAX_PATTERN; l++) begin
         hit[l] = 1'b1;
         for (int i = 0; i < l; i++) begin
            if (pattern[8*i +: 8] != window[l-1-i]) begin
               hit[l] = 1'b0;
            end
         end
         sel[l] = (int'(length) == l) || (int'(length) > MAX_PATTERN && l == MAX_PATTERN);
         hit[l] = hit[l] && sel[l] && (int'(avail) >= l);
      end
      match = |hit;
   end

endmodule

`default_nettype wire
